// ----- sv/gce_pkg.sv -----
// ----------------------------------------------------------------------------
// gce_pkg: shared types, constants and microprogram
// Holds the field widths, the control word layout and the read-only
// microprogram that sequences the graph colouring search.
// ----------------------------------------------------------------------------
package gce_pkg;

  // Largest graph that the adjacency store holds.
  localparam int unsigned MAX_VERTICES = 16;

  // Field widths.
  localparam int unsigned VIDX_W   = 4;
  localparam int unsigned COLOR_W  = 5;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned COUNT_W  = 32;

  // Stream word widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // The search opens with two colours.
  localparam logic [COLOR_W-1:0] START_COLORS = COLOR_W'(2);

  // Microprogram addresses.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_CHK_DONE,
    ST_CHK_SELF,
    ST_START,
    ST_TRY,
    ST_TEST,
    ST_NEXT_C,
    ST_BACK,
    ST_POP,
    ST_LEVEL0,
    ST_RAISE,
    ST_FINISH,
    ST_PLACE,
    ST_PUSH,
    ST_SOLVED,
    ST_EMIT,
    ST_EXH,
    ST_GIVE_UP
  } step_e;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_LOAD,
    OP_START,
    OP_INC_C,
    OP_POP,
    OP_RAISE,
    OP_FINISH,
    OP_PUSH,
    OP_SOLVE,
    OP_EMIT,
    OP_EXH,
    OP_GIVE_UP
  } op_e;

  // Branch conditions tested by the sequencer.
  typedef enum logic [3:0] {
    CD_ALWAYS,
    CD_ACCEPT,
    CD_IS_LOAD,
    CD_DONE,
    CD_SELF_LOOP,
    CD_C_OVER,
    CD_FITS,
    CD_P_ZERO,
    CD_STOP,
    CD_LAST_V,
    CD_EMIT_END,
    CD_SLOT_FREE
  } cond_e;

  // One control word: operation, condition, address when the condition
  // holds and address when it does not.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
    step_e next;
  } uword_t;

  // The microprogram itself.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '{op: OP_NOP, cond: CD_ALWAYS, target: ST_IDLE, next: ST_IDLE};
    unique case (s)
      ST_IDLE:     w = '{OP_WAIT,    CD_ACCEPT,    ST_DISPATCH, ST_IDLE};
      ST_DISPATCH: w = '{OP_NOP,     CD_IS_LOAD,   ST_LOAD,     ST_CHK_DONE};
      ST_LOAD:     w = '{OP_LOAD,    CD_ALWAYS,    ST_IDLE,     ST_IDLE};
      ST_CHK_DONE: w = '{OP_NOP,     CD_DONE,      ST_EXH,      ST_CHK_SELF};
      ST_CHK_SELF: w = '{OP_NOP,     CD_SELF_LOOP, ST_GIVE_UP,  ST_START};
      ST_START:    w = '{OP_START,   CD_ALWAYS,    ST_TRY,      ST_TRY};
      ST_TRY:      w = '{OP_NOP,     CD_C_OVER,    ST_BACK,     ST_TEST};
      ST_TEST:     w = '{OP_NOP,     CD_FITS,      ST_PLACE,    ST_NEXT_C};
      ST_NEXT_C:   w = '{OP_INC_C,   CD_ALWAYS,    ST_TRY,      ST_TRY};
      ST_BACK:     w = '{OP_NOP,     CD_P_ZERO,    ST_LEVEL0,   ST_POP};
      ST_POP:      w = '{OP_POP,     CD_ALWAYS,    ST_TRY,      ST_TRY};
      ST_LEVEL0:   w = '{OP_NOP,     CD_STOP,      ST_FINISH,   ST_RAISE};
      ST_RAISE:    w = '{OP_RAISE,   CD_ALWAYS,    ST_TRY,      ST_TRY};
      ST_FINISH:   w = '{OP_FINISH,  CD_ALWAYS,    ST_EXH,      ST_EXH};
      ST_PLACE:    w = '{OP_NOP,     CD_LAST_V,    ST_SOLVED,   ST_PUSH};
      ST_PUSH:     w = '{OP_PUSH,    CD_ALWAYS,    ST_TRY,      ST_TRY};
      ST_SOLVED:   w = '{OP_SOLVE,   CD_ALWAYS,    ST_EMIT,     ST_EMIT};
      ST_EMIT:     w = '{OP_EMIT,    CD_EMIT_END,  ST_IDLE,     ST_EMIT};
      ST_EXH:      w = '{OP_EXH,     CD_SLOT_FREE, ST_IDLE,     ST_EXH};
      ST_GIVE_UP:  w = '{OP_GIVE_UP, CD_ALWAYS,    ST_EXH,      ST_EXH};
      default:     w = '{OP_NOP,     CD_ALWAYS,    ST_IDLE,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/graph_coloring_enumerator.sv -----
// ----------------------------------------------------------------------------
// graph_coloring_enumerator: backtracking m-colouring enumerator
// Loads adjacency rows and, on request, resumes a depth-first search that
// lists every proper colouring at the least working colour count, at least two.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         tuser: mode; tdata: row_index, row_bits
//  m_axis    out        tuser: exhausted; tlast: last;
//                       tdata: vertex_index, color, min_colors, solution_number
//  cfg       in         data: vertex_count
//
// A request runs set-up steps, then try, test and next-colour for each colour
// rejected, try, back and pop for each pop of the search stack, try, test, place
// and push for each push, try, back, level-zero and raise for each raise of the
// colour count, and one emit step per vertex result sent. The microcoded
// sequencer runs one control word per cycle. Reset clears the search state; the
// adjacency rows are undefined until loaded. A stalled output holds the sequencer
// in its emit step and keeps the input waiting; the next word is taken once the
// final result has entered the output register.
//
module graph_coloring_enumerator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata, from bit 0: row_index, row_bits, zero fill
  input  logic [gce_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // tuser: mode
  input  logic                               s_axis_tuser_i,
  // Output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata, from bit 0: vertex_index, color, min_colors, solution_number, zero fill
  output logic [gce_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // tuser: exhausted
  output logic                               m_axis_tuser_o,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gce_pkg::COLOR_W-1:0]        cfg_data_i
);
  import gce_pkg::*;

  // Sequencer
  step_e                upc_q, upc_d;
  uword_t               uw;
  logic                 cond_true;

  // Configuration and search state
  logic [COLOR_W-1:0]   vcount_q;
  logic [ROW_W-1:0]     adj_q [MAX_VERTICES];
  logic [COLOR_W-1:0]   colors_q [MAX_VERTICES];
  logic [VIDX_W-1:0]    p_q;
  logic [VIDX_W-1:0]    k_q;
  logic [COLOR_W-1:0]   c_q;
  logic [COLOR_W-1:0]   depth_q;
  logic [COLOR_W-1:0]   limit_q;
  logic                 found_q;
  logic                 done_q;
  logic [COUNT_W-1:0]   count_q;

  // Captured input word
  logic                 in_mode_q;
  logic [VIDX_W-1:0]    in_row_q;
  logic [ROW_W-1:0]     in_bits_q;

  // Output register
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                 out_last_q;
  logic                 out_ex_q;

  // Derived values
  logic [COLOR_W-1:0]   n_v;
  logic [VIDX_W-1:0]    n_last;
  logic [COLOR_W-1:0]   bound;
  logic [VIDX_W-1:0]    p_start;
  logic [ROW_W-1:0]     row_p;
  logic                 self_loop;
  logic                 fits;
  logic                 slot_free;
  logic                 in_accept;
  logic                 cfg_accept;
  logic                 restart;

  // Current control word.
  assign uw = ucode(upc_q);

  // Handshakes.
  assign s_axis_tready_o = (uw.op == OP_WAIT);
  assign in_accept       = s_axis_tready_o && s_axis_tvalid_i;
  assign cfg_ready_o     = 1'b1;
  assign cfg_accept      = cfg_valid_i;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign restart         = cfg_accept || (uw.op == OP_LOAD);

  // Vertex count in use and the colour count bound.
  always_comb begin
    if (vcount_q == '0) begin
      n_v = COLOR_W'(1);
    end else if (vcount_q > COLOR_W'(MAX_VERTICES)) begin
      n_v = COLOR_W'(MAX_VERTICES);
    end else begin
      n_v = vcount_q;
    end
  end

  assign n_last  = VIDX_W'(n_v - COLOR_W'(1));
  assign bound   = (n_v > START_COLORS) ? n_v : START_COLORS;
  assign p_start = (depth_q >= n_v) ? n_last : depth_q[VIDX_W-1:0];
  assign row_p   = adj_q[p_q];

  // Self-loop check over the vertices in use.
  always_comb begin
    self_loop = 1'b0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if ((COLOR_W'(v) < n_v) && adj_q[v][v]) begin
        self_loop = 1'b1;
      end
    end
  end

  // Candidate colour test against every vertex placed below the current one.
  always_comb begin
    fits = 1'b1;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if ((VIDX_W'(j) < p_q) && (colors_q[j] == c_q) && (row_p[j] || adj_q[j][p_q])) begin
        fits = 1'b0;
      end
    end
  end

  // Branch condition decode.
  always_comb begin
    unique case (uw.cond)
      CD_ALWAYS:    cond_true = 1'b1;
      CD_ACCEPT:    cond_true = in_accept;
      CD_IS_LOAD:   cond_true = !in_mode_q;
      CD_DONE:      cond_true = done_q;
      CD_SELF_LOOP: cond_true = self_loop;
      CD_C_OVER:    cond_true = (c_q > limit_q);
      CD_FITS:      cond_true = fits;
      CD_P_ZERO:    cond_true = (p_q == '0);
      CD_STOP:      cond_true = found_q || (limit_q >= bound);
      CD_LAST_V:    cond_true = (p_q == n_last);
      CD_EMIT_END:  cond_true = slot_free && (k_q == n_last);
      CD_SLOT_FREE: cond_true = slot_free;
      default:      cond_true = 1'b1;
    endcase
  end

  assign upc_d = cond_true ? uw.target : uw.next;

  // Sequencer, search state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_IDLE;
      vcount_q    <= COLOR_W'(1);
      for (int i = 0; i < MAX_VERTICES; i++) begin
        colors_q[i] <= '0;
      end
      p_q         <= '0;
      k_q         <= '0;
      c_q         <= '0;
      depth_q     <= '0;
      limit_q     <= START_COLORS;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;

      // Output valid follows loads and drains of the output register.
      if (((uw.op == OP_EMIT) || (uw.op == OP_EXH)) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_accept) begin
        vcount_q <= cfg_data_i;
      end

      if (restart) begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          colors_q[i] <= '0;
        end
        depth_q <= '0;
        limit_q <= START_COLORS;
        found_q <= 1'b0;
        done_q  <= 1'b0;
        count_q <= '0;
      end else begin
        case (uw.op)
          OP_START: begin
            p_q <= p_start;
            c_q <= colors_q[p_start] + COLOR_W'(1);
          end
          OP_INC_C: begin
            c_q <= c_q + COLOR_W'(1);
          end
          OP_POP: begin
            colors_q[p_q] <= '0;
            p_q           <= p_q - VIDX_W'(1);
            c_q           <= colors_q[p_q - VIDX_W'(1)] + COLOR_W'(1);
          end
          OP_RAISE: begin
            colors_q[p_q] <= '0;
            limit_q       <= limit_q + COLOR_W'(1);
            c_q           <= COLOR_W'(1);
          end
          OP_FINISH: begin
            colors_q[p_q] <= '0;
            done_q        <= 1'b1;
            depth_q       <= '0;
          end
          OP_PUSH: begin
            colors_q[p_q] <= c_q;
            p_q           <= p_q + VIDX_W'(1);
            c_q           <= COLOR_W'(1);
          end
          OP_SOLVE: begin
            colors_q[p_q] <= c_q;
            depth_q       <= n_v;
            found_q       <= 1'b1;
            k_q           <= '0;
            if (count_q != '1) begin
              count_q <= count_q + COUNT_W'(1);
            end
          end
          OP_EMIT: begin
            if (slot_free) begin
              k_q <= k_q + VIDX_W'(1);
            end
          end
          OP_GIVE_UP: begin
            done_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Adjacency rows, input capture and output word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q <= s_axis_tuser_i;
      in_row_q  <= s_axis_tdata_i[VIDX_W-1:0];
      in_bits_q <= s_axis_tdata_i[VIDX_W +: ROW_W];
    end

    if (uw.op == OP_LOAD) begin
      adj_q[in_row_q] <= in_bits_q;
    end

    if ((uw.op == OP_EMIT) && slot_free) begin
      out_data_q <= {2'b00, count_q, limit_q, colors_q[k_q], k_q};
      out_last_q <= (k_q == n_last);
      out_ex_q   <= 1'b0;
    end else if ((uw.op == OP_EXH) && slot_free) begin
      out_data_q <= {2'b00, count_q, (found_q ? limit_q : COLOR_W'(0)),
                     COLOR_W'(0), VIDX_W'(0)};
      out_last_q <= 1'b1;
      out_ex_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ex_q;

endmodule

// ----- tb/tb_graph_coloring_enumerator.sv -----
// ----------------------------------------------------------------------------
// tb_graph_coloring_enumerator: self-checking bench for the colouring enumerator
// Loads adjacency rows and requests colourings over the input stream, and
// checks every output word against a behavioural search kept in the bench.
// Directed graphs cover the corner cases; random small graphs follow, with
// random gaps on both streams and one long hold-off on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_graph_coloring_enumerator;

  localparam int unsigned NV            = gce_pkg::MAX_VERTICES;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_OFF      = 400;
  localparam int unsigned RANDOM_ITEMS  = 130;

  typedef enum bit {MODE_LOAD = 1'b0, MODE_NEXT = 1'b1} mode_e;

  // One output word split into its fields.
  typedef struct {
    logic [gce_pkg::VIDX_W-1:0]  vertex;
    logic [gce_pkg::COLOR_W-1:0] colour;
    logic [gce_pkg::COLOR_W-1:0] min_colours;
    logic [gce_pkg::COUNT_W-1:0] ordinal;
    logic                        last;
    logic                        exhausted;
  } colour_word_t;

  // Clock, reset and stream signals.
  logic                              clk_i  = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_tvalid = 1'b0;
  logic [gce_pkg::IN_DATA_W-1:0]     s_tdata  = '0;
  logic                              s_tuser  = 1'b0;
  logic                              s_tready;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [gce_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic                              m_tlast;
  logic                              m_tuser;
  logic                              cfg_valid = 1'b0;
  logic [gce_pkg::COLOR_W-1:0]       cfg_data  = '0;
  logic                              cfg_ready;

  // Bench controls and tallies.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned requests_sent  = 0;
  int unsigned loads_sent     = 0;
  int unsigned configs_written = 0;
  int unsigned random_items   = 0;

  // Words the search is still due to send, oldest first.
  colour_word_t words_due[$];

  // Bench copy of the search state.
  logic [gce_pkg::ROW_W-1:0]   adj_rows [NV];
  int unsigned                 stack_colours [NV];
  int unsigned                 depth_m;
  int unsigned                 limit_m;
  bit                          found_m;
  bit                          done_m;
  logic [gce_pkg::COUNT_W-1:0] solutions_m;
  logic [gce_pkg::COLOR_W-1:0] vcount_m;

  graph_coloring_enumerator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- search

  function automatic void restart_search();
    for (int unsigned v = 0; v < NV; v++) begin
      stack_colours[v] = 0;
    end
    depth_m     = 0;
    limit_m     = 2;
    found_m     = 1'b0;
    done_m      = 1'b0;
    solutions_m = '0;
  endfunction

  // A count of zero behaves as one vertex, anything above the store as full size.
  function automatic int unsigned active_vertices();
    if (vcount_m == 0) return 1;
    if (vcount_m > NV) return NV;
    return vcount_m;
  endfunction

  function automatic bit adjacent(int unsigned a, int unsigned b);
    return adj_rows[a][b] || adj_rows[b][a];
  endfunction

  function automatic bit colour_free(int unsigned p, int unsigned c);
    for (int unsigned j = 0; j < p; j++) begin
      if (stack_colours[j] == c && adjacent(p, j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_exhausted();
    colour_word_t w;
    w.vertex      = '0;
    w.colour      = '0;
    w.min_colours = found_m ? limit_m[gce_pkg::COLOR_W-1:0] : '0;
    w.ordinal     = solutions_m;
    w.last        = 1'b1;
    w.exhausted   = 1'b1;
    words_due.push_back(w);
  endfunction

  // Resumes the backtracking search and queues the words one request yields.
  function automatic void predict_next_colouring();
    int unsigned  n;
    int unsigned  bound;
    int unsigned  p;
    int unsigned  c;
    bit           self_loop;
    bit           finished;
    colour_word_t w;
    n = active_vertices();
    bound = (n > 2) ? n : 2;
    self_loop = 1'b0;
    finished = 1'b0;
    if (done_m) begin
      push_exhausted();
      return;
    end
    for (int unsigned v = 0; v < n; v++) begin
      if (adj_rows[v][v]) self_loop = 1'b1;
    end
    if (self_loop) begin
      done_m = 1'b1;
      push_exhausted();
      return;
    end
    p = (depth_m >= n) ? n - 1 : depth_m;
    while (!finished) begin
      c = stack_colours[p] + 1;
      while (c <= limit_m && !colour_free(p, c)) c++;
      if (c <= limit_m) begin
        stack_colours[p] = c;
        p++;
        if (p == n) begin
          depth_m = n;
          found_m = 1'b1;
          if (solutions_m != '1) solutions_m++;
          for (int unsigned k = 0; k < n; k++) begin
            w.vertex      = k[gce_pkg::VIDX_W-1:0];
            w.colour      = stack_colours[k][gce_pkg::COLOR_W-1:0];
            w.min_colours = limit_m[gce_pkg::COLOR_W-1:0];
            w.ordinal     = solutions_m;
            w.last        = (k == n - 1);
            w.exhausted   = 1'b0;
            words_due.push_back(w);
          end
          finished = 1'b1;
        end else begin
          stack_colours[p] = 0;
        end
      end else begin
        stack_colours[p] = 0;
        if (p == 0) begin
          // Level zero is out of colours: stop, or try one more colour.
          if (found_m || limit_m >= bound) begin
            done_m  = 1'b1;
            depth_m = 0;
            push_exhausted();
            finished = 1'b1;
          end else begin
            limit_m++;
          end
        end else begin
          p--;
        end
      end
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic int pick_gap(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one word on the input stream and updates the search once it is taken.
  task automatic send_word(mode_e mode, logic [3:0] row, logic [15:0] bits);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0000, bits, row};
    do @(posedge clk_i); while (!s_tready);
    if (mode == MODE_LOAD) begin
      adj_rows[row] = bits;
      restart_search();
      loads_sent++;
    end else begin
      predict_next_colouring();
      requests_sent++;
    end
  endtask

  task automatic request_colourings(int unsigned count);
    repeat (count) send_word(MODE_NEXT, '0, '0);
  endtask

  // Lets every due word arrive and the block fall idle.
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(logic [4:0] value);
    drain_and_settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    vcount_m = value;
    restart_search();
    configs_written++;
    cfg_valid <= 1'b0;
  endtask

  // Random row: edges among the used vertices at the given density, random
  // bits above them, and no self-loop.
  function automatic logic [15:0] random_row(int unsigned v, int unsigned n, int density);
    logic [15:0] row;
    row = 16'($urandom);
    for (int unsigned j = 0; j < n; j++) begin
      row[j] = ($urandom_range(0, 99) < density);
    end
    row[v] = 1'b0;
    return row;
  endfunction

  // ---------------------------------------------------------------- tests

  // One vertex: both colours, exhaustion and its repeat, a self-loop, count zero.
  task automatic test_single_vertex();
    write_vertex_count(5'd1);
    send_word(MODE_LOAD, 4'd0, 16'h0000);
    request_colourings(4);
    send_word(MODE_LOAD, 4'd0, 16'h0001);
    request_colourings(2);
    write_vertex_count(5'd0);
    send_word(MODE_LOAD, 4'd0, 16'hFFFE);
    request_colourings(1);
  endtask

  // Triangle: two colours fail, then all six three-colourings and exhaustion.
  task automatic test_triangle();
    write_vertex_count(5'd3);
    send_word(MODE_LOAD, 4'd0, 16'h0006);
    send_word(MODE_LOAD, 4'd1, 16'h0000);
    send_word(MODE_LOAD, 4'd2, 16'h0002);
    send_word(MODE_LOAD, 4'd15, 16'hFFFF);
    request_colourings(8);
  endtask

  // Full-size graphs: a path, an odd cycle and an empty graph, with counts
  // above the store size.
  task automatic test_full_size_graphs();
    write_vertex_count(5'd31);
    for (int unsigned v = 0; v < NV; v++) begin
      send_word(MODE_LOAD, v[3:0], (v < NV - 1) ? 16'(1 << (v + 1)) : 16'h0000);
    end
    request_colourings(3);
    write_vertex_count(5'd15);
    send_word(MODE_LOAD, 4'd14, 16'h0001);
    request_colourings(2);
    write_vertex_count(5'd17);
    for (int unsigned v = 0; v < NV; v++) begin
      send_word(MODE_LOAD, v[3:0], 16'h0000);
    end
    request_colourings(2);
    write_vertex_count(5'd16);
    request_colourings(1);
  endtask

  // Random small graphs, each loaded whole and then walked through.
  task automatic test_random_graphs();
    int unsigned n;
    int unsigned count;
    int          density;
    logic [3:0]  row;
    logic [15:0] bits;
    while (random_items < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 99) < 15) ? 7 : $urandom_range(1, 6);
      density = (n == 7) ? $urandom_range(10, 45) : $urandom_range(0, 90);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      write_vertex_count(n[4:0]);
      for (int unsigned v = 0; v < n; v++) begin
        bits = random_row(v, n, density);
        if ($urandom_range(0, 99) < 4) bits[v] = 1'b1;
        send_word(MODE_LOAD, v[3:0], bits);
        random_items++;
      end
      count = $urandom_range(3, 14);
      repeat (count) begin
        if ($urandom_range(0, 99) < 8) begin
          // Stray reload: any row, random content, and the search starts over.
          row = 4'($urandom_range(0, NV - 1));
          send_word(MODE_LOAD, row, (row < n) ? random_row(row, n, density) : 16'($urandom));
        end else begin
          send_word(MODE_NEXT, 4'($urandom), 16'($urandom));
        end
        random_items++;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Output held off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    write_vertex_count(5'd4);
    for (int unsigned v = 0; v < 4; v++) begin
      send_word(MODE_LOAD, v[3:0], 16'h0000);
    end
    tx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    request_colourings(14);
    tx_idle_on = 1'b1;
    drain_and_settle();
  endtask

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Compares each accepted output word with the oldest one due.
  always @(posedge clk_i) begin
    colour_word_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_tdata));
      end else begin
        want = words_due.pop_front();
        check_field("vertex_index", 32'(m_tdata[3:0]), 32'(want.vertex));
        check_field("color", 32'(m_tdata[8:4]), 32'(want.colour));
        check_field("min_colors", 32'(m_tdata[13:9]), 32'(want.min_colours));
        check_field("solution_number", m_tdata[45:14], want.ordinal);
        check_field("last", 32'(m_tlast), 32'(want.last));
        check_field("exhausted", 32'(m_tuser), 32'(want.exhausted));
        words_checked++;
      end
    end
  end

  // Output ready: random stalls, and one long hold-off on request.
  initial begin : rx_ready_gen
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        gap = pick_gap(rx_idle_on);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence.
  initial begin
    vcount_m = 5'd1;
    for (int unsigned v = 0; v < NV; v++) begin
      adj_rows[v] = '0;
    end
    restart_search();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_vertex();
    test_triangle();
    test_full_size_graphs();
    test_random_graphs();
    test_output_backpressure();
    drain_and_settle();

    $display("Covered %0d row loads, %0d colouring requests and %0d register writes.",
             loads_sent, requests_sent, configs_written);
    $display("Checked %0d output words; %0d mismatches.", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
